// ===== hw/rtl/alba_pkg.sv =====
// ----------------------------------------------------------------------------
// alba_pkg: shared types and constants of the block allocator
// Field widths, command codes, controller/datapath handshake structs and the
// power-of-two round-up helper.
// ----------------------------------------------------------------------------
package alba_pkg;

    localparam int unsigned DATA_W    = 40;   // block sizes, offsets, sums
    localparam int unsigned REQ_W     = 32;   // requested size
    localparam int unsigned LG_W      = 5;    // alignment exponent
    localparam int unsigned MIN_W     = 33;   // min_block_size register
    localparam int unsigned IDX_OUT_W = 4;    // reported block index
    localparam int unsigned CNT_OUT_W = 5;    // reported counts

    localparam logic [DATA_W-1:0]    MASK40        = {DATA_W{1'b1}};
    localparam logic [MIN_W-1:0]     MIN_RESET     = 33'd1048576;
    localparam logic [CNT_OUT_W-1:0] MADE_SAT      = 5'd31;

    // input command codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_RESET = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic start;     // latch the input beat, clear scan state
        logic scan;      // table scan active
        logic decide;    // scan finished: latch result bookkeeping
        logic mk_max;    // new block size: max(source, minimum)
        logic mk_rnd;    // new block size: round up to largest alignment
        logic wr_new;    // write the new block entry
        logic wr_off;    // advance the offset of the chosen block
        logic out_load;  // move the result into the output register
    } alba_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_reset;
        logic found;
        logic full;
        logic multi;
        logic scan_done;
    } alba_stat_t;

    // Round v up to a multiple of 2^lg; clamp to the largest aligned
    // value within 40 bits when the sum overflows.
    function automatic logic [DATA_W-1:0] round_up(input logic [DATA_W-1:0] v,
                                                   input logic [LG_W-1:0] lg);
        logic [DATA_W:0]   a_m1;
        logic [DATA_W:0]   sum;
        logic [DATA_W-1:0] mask;
        a_m1 = ({{DATA_W{1'b0}}, 1'b1} << lg) - {{DATA_W{1'b0}}, 1'b1};
        sum  = {1'b0, v} + a_m1;
        mask = ~a_m1[DATA_W-1:0];
        if (sum[DATA_W])
        begin
            round_up = MASK40 & mask;
        end
        else
        begin
            round_up = sum[DATA_W-1:0] & mask;
        end
    endfunction

endpackage

// ===== hw/rtl/alba_ram.sv =====
// ----------------------------------------------------------------------------
// alba_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module alba_ram #(
    parameter int unsigned WIDTH = 40,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_W-1:0]    waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic                 re,
    input  logic [ADDR_W-1:0]    raddr,
    output logic [WIDTH-1:0]     rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hw/rtl/alba_ctrl.sv =====
// ----------------------------------------------------------------------------
// alba_ctrl: sequencing state machine of the block allocator
// Steps one item through scan, new-block sizing, table write and result.
// ----------------------------------------------------------------------------
module alba_ctrl
    import alba_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  alba_stat_t stat,
    output alba_cmd_t  cmd
);
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MKMAX,
        ST_MKRND,
        ST_WRNEW,
        ST_WROFF,
        ST_HOLD
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg & ~out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_done)
                begin
                    cmd.decide = 1'b1;
                    if (stat.is_reset)
                    begin
                        state_next = stat.multi ? ST_MKMAX : ST_HOLD;
                    end
                    else if (stat.found)
                    begin
                        state_next = ST_WROFF;
                    end
                    else
                    begin
                        state_next = stat.full ? ST_HOLD : ST_MKMAX;
                    end
                end
            end
            ST_MKMAX:
            begin
                cmd.mk_max = 1'b1;
                state_next = ST_MKRND;
            end
            ST_MKRND:
            begin
                cmd.mk_rnd = 1'b1;
                state_next = ST_WRNEW;
            end
            ST_WRNEW:
            begin
                cmd.wr_new = 1'b1;
                state_next = ST_HOLD;
            end
            ST_WROFF:
            begin
                cmd.wr_off = 1'b1;
                state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                // wait for a free output register
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== hw/rtl/alba_dp.sv =====
// ----------------------------------------------------------------------------
// alba_dp: datapath of the block allocator
// Block size/offset tables, pipelined fit scan, reset sums, new-block sizing
// and the result register.
// ----------------------------------------------------------------------------
module alba_dp
    import alba_pkg::*;
#(
    parameter int unsigned MAX_BLOCKS     = 16,
    parameter int unsigned MAX_ALIGN_LOG2 = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [MIN_W-1:0]      cfg_wdata,
    input  alba_cmd_t             cmd,
    output alba_stat_t            stat,
    input  logic                  in_command,
    input  logic [REQ_W-1:0]      in_alloc_size,
    input  logic [LG_W-1:0]       in_align_log2,
    output logic                  out_ok,
    output logic [IDX_OUT_W-1:0]  out_block_index,
    output logic [DATA_W-1:0]     out_offset,
    output logic                  out_new_block,
    output logic [DATA_W-1:0]     out_total_usage,
    output logic [DATA_W-1:0]     out_total_size,
    output logic [CNT_OUT_W-1:0]  out_block_count,
    output logic [CNT_OUT_W-1:0]  out_created_count
);
    localparam int unsigned IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam logic [LG_W-1:0]  ALIGN_MAX = LG_W'(MAX_ALIGN_LOG2);
    localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(MAX_BLOCKS);
    localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

    // control state
    logic [MIN_W-1:0]     min_reg;
    logic [CNT_W-1:0]     used_reg;
    logic [CNT_OUT_W-1:0] made_reg;
    logic [CNT_W-1:0]     addr_reg;
    logic                 p1_reg;
    logic                 p2_reg;
    logic                 found_reg;

    // payload
    logic                 cmd_reg;
    logic [REQ_W-1:0]     req_reg;
    logic [LG_W-1:0]      lg_reg;
    logic [IDX_W-1:0]     p1_idx_reg;
    logic [IDX_W-1:0]     p2_idx_reg;
    logic [DATA_W-1:0]    p2_aligned_reg;
    logic [DATA_W-1:0]    p2_size_reg;
    logic [IDX_W-1:0]     best_idx_reg;
    logic [DATA_W-1:0]    best_aligned_reg;
    logic [DATA_W-1:0]    usage_reg;
    logic [DATA_W-1:0]    total_reg;
    logic [DATA_W-1:0]    mk_reg;
    logic [DATA_W-1:0]    nsize_reg;
    logic                 res_fail_reg;
    logic                 res_new_reg;
    logic [IDX_W-1:0]     res_idx_reg;
    logic [DATA_W-1:0]    res_off_reg;
    logic [CNT_OUT_W-1:0] res_count_reg;
    logic [CNT_OUT_W-1:0] res_created_reg;

    // table ports
    logic              issue;
    logic [DATA_W-1:0] size_q;
    logic [DATA_W-1:0] off_q;
    logic              sz_we;
    logic              of_we;
    logic [IDX_W-1:0]  sz_waddr;
    logic [IDX_W-1:0]  of_waddr;
    logic [DATA_W-1:0] of_wdata;
    logic [IDX_W-1:0]  new_addr;

    logic [DATA_W:0]   usage_sum;
    logic [DATA_W:0]   total_sum;
    logic [DATA_W:0]   adv_sum;
    logic              fit;
    logic [DATA_W-1:0] mk_src;
    logic [DATA_W-1:0] min_ext;

    assign issue    = cmd.scan && (addr_reg < used_reg);
    assign new_addr = (cmd_reg == CMD_RESET) ? '0 : used_reg[IDX_W-1:0];
    assign adv_sum  = {1'b0, best_aligned_reg} + {9'd0, req_reg};

    assign usage_sum = {1'b0, usage_reg} + {1'b0, off_q};
    assign total_sum = {1'b0, total_reg} + {1'b0, size_q};

    assign fit = (p2_aligned_reg <= p2_size_reg)
              && ((p2_size_reg - p2_aligned_reg) >= {8'd0, req_reg});

    assign min_ext = {7'd0, min_reg};
    assign mk_src  = (cmd_reg == CMD_RESET) ? total_reg : {8'd0, req_reg};

    always_comb
    begin
        sz_we    = cmd.wr_new;
        sz_waddr = new_addr;
        of_we    = 1'b0;
        of_waddr = p1_idx_reg;
        of_wdata = '0;
        if (cmd.wr_new)
        begin
            of_we    = 1'b1;
            of_waddr = new_addr;
            of_wdata = (cmd_reg == CMD_RESET) ? '0 : {8'd0, req_reg};
        end
        else if (cmd.wr_off)
        begin
            of_we    = 1'b1;
            of_waddr = best_idx_reg;
            of_wdata = adv_sum[DATA_W-1:0];
        end
        else if (p1_reg && (cmd_reg == CMD_RESET))
        begin
            // clear offsets as the reset scan passes
            of_we = 1'b1;
        end
    end

    alba_ram #(.WIDTH(DATA_W), .DEPTH(MAX_BLOCKS)) u_sizes (
        .clk   (clk),
        .we    (sz_we),
        .waddr (sz_waddr),
        .wdata (nsize_reg),
        .re    (issue),
        .raddr (addr_reg[IDX_W-1:0]),
        .rdata (size_q)
    );

    alba_ram #(.WIDTH(DATA_W), .DEPTH(MAX_BLOCKS)) u_offsets (
        .clk   (clk),
        .we    (of_we),
        .waddr (of_waddr),
        .wdata (of_wdata),
        .re    (issue),
        .raddr (addr_reg[IDX_W-1:0]),
        .rdata (off_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg   <= MIN_RESET;
            used_reg  <= '0;
            made_reg  <= '0;
            addr_reg  <= '0;
            p1_reg    <= 1'b0;
            p2_reg    <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                min_reg <= cfg_wdata;
            end
            if (cmd.start)
            begin
                addr_reg  <= '0;
                found_reg <= 1'b0;
            end
            else if (issue)
            begin
                addr_reg <= addr_reg + CNT_ONE;
            end
            p1_reg <= issue;
            p2_reg <= p1_reg && (cmd_reg == CMD_ALLOC);
            if (p2_reg && fit)
            begin
                found_reg <= 1'b1;
            end
            if (cmd.decide && (cmd_reg == CMD_RESET))
            begin
                made_reg <= '0;
            end
            if (cmd.wr_new)
            begin
                if (cmd_reg == CMD_RESET)
                begin
                    used_reg <= CNT_ONE;
                end
                else
                begin
                    used_reg <= used_reg + CNT_ONE;
                    if (made_reg != MADE_SAT)
                    begin
                        made_reg <= made_reg + 5'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            cmd_reg   <= in_command;
            req_reg   <= in_alloc_size;
            lg_reg    <= (in_align_log2 > ALIGN_MAX) ? ALIGN_MAX : in_align_log2;
            usage_reg <= '0;
            total_reg <= '0;
        end
        else if (p1_reg && (cmd_reg == CMD_RESET))
        begin
            usage_reg <= usage_sum[DATA_W] ? MASK40 : usage_sum[DATA_W-1:0];
            total_reg <= total_sum[DATA_W] ? MASK40 : total_sum[DATA_W-1:0];
        end

        p1_idx_reg     <= addr_reg[IDX_W-1:0];
        p2_idx_reg     <= p1_idx_reg;
        p2_aligned_reg <= round_up(off_q, lg_reg);
        p2_size_reg    <= size_q;

        if (p2_reg && fit)
        begin
            best_idx_reg     <= p2_idx_reg;
            best_aligned_reg <= p2_aligned_reg;
        end

        if (cmd.decide)
        begin
            res_fail_reg    <= (cmd_reg == CMD_ALLOC) && !found_reg && stat.full;
            res_new_reg     <= (cmd_reg == CMD_ALLOC) && !found_reg && !stat.full;
            res_idx_reg     <= found_reg ? best_idx_reg : used_reg[IDX_W-1:0];
            res_off_reg     <= found_reg ? best_aligned_reg : '0;
            res_count_reg   <= CNT_OUT_W'(used_reg);
            res_created_reg <= made_reg;
        end

        if (cmd.mk_max)
        begin
            mk_reg <= (mk_src > min_ext) ? mk_src : min_ext;
        end
        if (cmd.mk_rnd)
        begin
            nsize_reg <= round_up(mk_reg, ALIGN_MAX);
        end

        if (cmd.out_load)
        begin
            if (cmd_reg == CMD_RESET)
            begin
                out_ok            <= 1'b1;
                out_block_index   <= '0;
                out_offset        <= '0;
                out_new_block     <= 1'b0;
                out_total_usage   <= usage_reg;
                out_total_size    <= total_reg;
                out_block_count   <= res_count_reg;
                out_created_count <= res_created_reg;
            end
            else
            begin
                // a full table reports all zeros
                out_ok            <= !res_fail_reg;
                out_block_index   <= res_fail_reg ? '0 : IDX_OUT_W'(res_idx_reg);
                out_offset        <= res_fail_reg ? '0 : res_off_reg;
                out_new_block     <= res_new_reg;
                out_total_usage   <= '0;
                out_total_size    <= '0;
                out_block_count   <= '0;
                out_created_count <= '0;
            end
        end
    end

    assign stat.is_reset  = (cmd_reg == CMD_RESET);
    assign stat.found     = found_reg;
    assign stat.full      = (used_reg >= CNT_MAX);
    assign stat.multi     = (used_reg > CNT_ONE);
    assign stat.scan_done = (addr_reg >= used_reg) && !p1_reg && !p2_reg;

endmodule

// ===== hw/rtl/aligned_linear_block_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// aligned_linear_block_allocator_unit: multi-block aligned bump allocator
// Block table with per-block bump offsets; serves allocate and reset beats.
// ----------------------------------------------------------------------------
// Usage
//   s_axis carries one request per beat: tuser[0] is the command (0 allocate,
//   1 reset and compact), tdata holds the size and the alignment exponent.
//   m_axis returns exactly one result beat per request, in order.
//   cfg_we/cfg_wdata write min_block_size; write it only while idle.
// Sequencing and throughput
//   Requests are worked one at a time. Each result follows the table scan and,
//   when an existing block fits, an offset write; when a new block is
//   appended, new-block sizing and a table write; nothing more on a full table.
//   A reset skips the compare stage; with compaction it then sizes and writes
//   one new block. On an empty table no table entry is read. The table scan
//   reads the size and offset RAMs one entry per cycle through a two-stage
//   align-and-compare pipeline.
// Reset and stall
//   rst_n clears the table (no blocks), the creation counter and restores
//   min_block_size to 1 MiB. The table RAMs need no clearing pass.
//   A finished result sits in the output register until m_axis_tready; the
//   next request is taken and scanned meanwhile and waits only for the
//   output register before it is delivered.
// ----------------------------------------------------------------------------
module aligned_linear_block_allocator_unit
    import alba_pkg::*;
#(
    parameter int unsigned MAX_BLOCKS     = 16,
    parameter int unsigned MAX_ALIGN_LOG2 = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    // configuration
    input  logic           cfg_we,
    input  logic [32:0]    cfg_wdata,       // min_block_size
    // request stream
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    input  logic [39:0]    s_axis_tdata,    // alloc_size[31:0], align_log2[36:32]
    input  logic [0:0]     s_axis_tuser,    // command[0]
    // result stream
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    output logic [135:0]   m_axis_tdata,    // block_index[3:0], offset[43:4],
                                            // total_usage[83:44],
                                            // total_size[123:84],
                                            // block_count[128:124],
                                            // created_count[133:129]
    output logic [1:0]     m_axis_tuser     // ok[0], new_block[1]
);
    alba_cmd_t  cmd;
    alba_stat_t stat;

    logic                 res_ok;
    logic [IDX_OUT_W-1:0] res_block_index;
    logic [DATA_W-1:0]    res_offset;
    logic                 res_new_block;
    logic [DATA_W-1:0]    res_total_usage;
    logic [DATA_W-1:0]    res_total_size;
    logic [CNT_OUT_W-1:0] res_block_count;
    logic [CNT_OUT_W-1:0] res_created_count;

    // sequencing: accept, scan, size and write, then hand off the result
    alba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // table, scan pipeline, sums and the output register
    alba_dp #(
        .MAX_BLOCKS     (MAX_BLOCKS),
        .MAX_ALIGN_LOG2 (MAX_ALIGN_LOG2)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .cmd               (cmd),
        .stat              (stat),
        .in_command        (s_axis_tuser[0]),
        .in_alloc_size     (s_axis_tdata[31:0]),
        .in_align_log2     (s_axis_tdata[36:32]),
        .out_ok            (res_ok),
        .out_block_index   (res_block_index),
        .out_offset        (res_offset),
        .out_new_block     (res_new_block),
        .out_total_usage   (res_total_usage),
        .out_total_size    (res_total_size),
        .out_block_count   (res_block_count),
        .out_created_count (res_created_count)
    );

    // pack the result beat, lowest field first, pad to whole bytes
    assign m_axis_tdata = {2'b00, res_created_count, res_block_count,
                           res_total_size, res_total_usage,
                           res_offset, res_block_index};
    assign m_axis_tuser = {res_new_block, res_ok};

endmodule

// ===== tb/sv/alba_result_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// alba_result_checker: result checker for the aligned block allocator
// Watches the request, result and configuration ports, keeps its own copy of
// the block table, and compares each result beat with the oldest owed result.
// ----------------------------------------------------------------------------
module alba_result_checker
    import alba_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [32:0]  cfg_wdata,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [39:0]  s_axis_tdata,     // alloc_size[31:0], align_log2[36:32]
    input  logic [0:0]   s_axis_tuser,     // command[0]
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [135:0] m_axis_tdata,     // block_index, offset, total_usage,
                                           // total_size, block_count,
                                           // created_count
    input  logic [1:0]   m_axis_tuser,     // ok[0], new_block[1]
    output int           fail_count,
    output int           pending
);

    localparam int unsigned TABLE_DEPTH = 16;
    localparam int unsigned ALIGN_CAP   = 16;
    localparam int unsigned MADE_LIMIT  = 31;
    localparam logic [63:0] SAT40       = 64'hFF_FFFF_FFFF;

    typedef struct packed {
        logic        ok;
        logic [3:0]  block_index;
        logic [39:0] offset;
        logic        new_block;
        logic [39:0] total_usage;
        logic [39:0] total_size;
        logic [4:0]  block_count;
        logic [4:0]  created_count;
    } alloc_result_t;

    logic [39:0]   blk_size [TABLE_DEPTH];
    logic [39:0]   blk_off  [TABLE_DEPTH];
    int unsigned   n_blocks;
    int unsigned   n_made;
    logic [32:0]   min_size;
    alloc_result_t owed_results [$];

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    // round up to a power of two, clamped to the top aligned 40-bit value
    function automatic logic [63:0] round_to_pow2(input logic [63:0] v,
                                                  input int unsigned lg);
        logic [63:0] a;
        logic [63:0] r;
        a = 64'd1 << lg;
        r = (v + a - 64'd1) & ~(a - 64'd1);
        if (r > SAT40)
            r = SAT40 & ~(a - 64'd1);
        return r;
    endfunction

    task automatic grow_block(input logic [63:0] req, output logic [39:0] sz);
        logic [63:0] s;
        s = (req > 64'(min_size)) ? req : 64'(min_size);
        if (s > SAT40)
            s = SAT40;
        if (n_made < MADE_LIMIT)
            n_made++;
        sz = 40'(round_to_pow2(s, ALIGN_CAP));
    endtask

    task automatic apply_request(input logic cmd, input logic [31:0] size,
                                 input logic [4:0] lg_in, output alloc_result_t r);
        int unsigned lg;
        int unsigned idx;
        int unsigned i;
        logic        found;
        logic [39:0] fresh;
        logic [63:0] aligned;
        logic [63:0] usage;
        logic [63:0] total;
        r = '0;
        if (cmd == CMD_ALLOC)
        begin
            lg    = (lg_in > ALIGN_CAP) ? ALIGN_CAP : int'(lg_in);
            found = 1'b0;
            idx   = 0;
            // the last fitting block wins
            for (i = 0; i < n_blocks; i++)
            begin
                aligned = round_to_pow2(64'(blk_off[i]), lg);
                if (aligned <= 64'(blk_size[i]) &&
                    64'(blk_size[i]) - aligned >= 64'(size))
                begin
                    found = 1'b1;
                    idx   = i;
                end
            end
            if (!found && n_blocks < TABLE_DEPTH)
            begin
                idx = n_blocks;
                grow_block(64'(size), fresh);
                blk_size[idx] = fresh;
                blk_off[idx]  = '0;
                n_blocks++;
                r.new_block = 1'b1;
                found       = 1'b1;
            end
            if (found)
            begin
                aligned       = round_to_pow2(64'(blk_off[idx]), lg);
                blk_off[idx]  = 40'(aligned + 64'(size));
                r.ok          = 1'b1;
                r.block_index = 4'(idx);
                r.offset      = 40'(aligned);
            end
        end
        else
        begin
            usage = '0;
            total = '0;
            for (i = 0; i < n_blocks; i++)
            begin
                usage = usage + 64'(blk_off[i]);
                if (usage > SAT40)
                    usage = SAT40;
                total = total + 64'(blk_size[i]);
                if (total > SAT40)
                    total = SAT40;
                blk_off[i] = '0;
            end
            r.ok            = 1'b1;
            r.total_usage   = 40'(usage);
            r.total_size    = 40'(total);
            r.block_count   = 5'(n_blocks);
            r.created_count = 5'(n_made);
            // compact several blocks into one of at least the total size
            if (n_blocks > 1)
            begin
                grow_block(total, fresh);
                blk_size[0] = fresh;
                blk_off[0]  = '0;
                n_blocks    = 1;
            end
            n_made = 0;
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        alloc_result_t want;
        alloc_result_t fresh_result;
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                blk_size[i] = '0;
                blk_off[i]  = '0;
            end
            n_blocks = 0;
            n_made   = 0;
            min_size = MIN_RESET;
            owed_results.delete();
            pending = 0;
        end
        else
        begin
            if (cfg_we)
                min_size = cfg_wdata;
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (owed_results.size() == 0)
                begin
                    $error("result beat with no request outstanding");
                    fail_count++;
                end
                else
                begin
                    want = owed_results.pop_front();
                    check_field("ok", 64'(want.ok), 64'(m_axis_tuser[0]));
                    check_field("new_block", 64'(want.new_block), 64'(m_axis_tuser[1]));
                    check_field("block_index", 64'(want.block_index),
                                64'(m_axis_tdata[3:0]));
                    check_field("offset", 64'(want.offset), 64'(m_axis_tdata[43:4]));
                    check_field("total_usage", 64'(want.total_usage),
                                64'(m_axis_tdata[83:44]));
                    check_field("total_size", 64'(want.total_size),
                                64'(m_axis_tdata[123:84]));
                    check_field("block_count", 64'(want.block_count),
                                64'(m_axis_tdata[128:124]));
                    check_field("created_count", 64'(want.created_count),
                                64'(m_axis_tdata[133:129]));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                apply_request(s_axis_tuser[0], s_axis_tdata[31:0], s_axis_tdata[36:32],
                              fresh_result);
                owed_results = {owed_results, fresh_result};
            end
            pending = owed_results.size();
        end
    end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the aligned block allocator
// Drives a directed opening (empty table, extreme fields, table full,
// compaction) and then random allocate/reset episodes under four minimum
// block sizes, with random gaps on both streams. A checker beside the block
// predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_top
    import alba_pkg::*;
();

    localparam int unsigned CYCLE_LIMIT  = 500000;
    localparam int unsigned IDLE_PCT     = 33;
    localparam int unsigned PHASE_ITEMS  = 420;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned TABLE_DEPTH  = 16;
    localparam logic [31:0] SIZE_MAX     = 32'hFFFF_FFFF;
    localparam logic [32:0] MIN_LOW      = 33'd65536;
    localparam logic [32:0] MIN_HIGH     = 33'h1_0000_0000;

    logic           clk           = 1'b0;
    logic           rst_n         = 1'b0;
    logic           cfg_we        = 1'b0;
    logic [32:0]    cfg_wdata     = '0;
    logic           s_axis_tvalid = 1'b0;
    logic           s_axis_tready;
    logic [39:0]    s_axis_tdata  = '0;     // alloc_size[31:0], align_log2[36:32]
    logic [0:0]     s_axis_tuser  = '0;     // command[0]
    logic           m_axis_tvalid;
    logic           m_axis_tready = 1'b0;
    logic [135:0]   m_axis_tdata;           // block_index[3:0], offset[43:4],
                                            // total_usage[83:44], total_size[123:84],
                                            // block_count[128:124],
                                            // created_count[133:129]
    logic [1:0]     m_axis_tuser;           // ok[0], new_block[1]

    int             fail_count;
    int             pending;
    int unsigned    cycle_count = 0;
    logic           steady      = 1'b0;     // high: neither side idles
    logic [32:0]    cur_min     = MIN_RESET;

    aligned_linear_block_allocator_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    alba_result_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    always #10 clk = ~clk;

    // Watchdog: a hung handshake or a lost result ends here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Result side back-pressure: drop tready about a third of the time,
    // hold it high through the steady stretch.
    always @(negedge clk)
    begin
        m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Present one request beat and hold it until the block takes it.
    // Returns at the falling edge after acceptance with tvalid still high,
    // so back-to-back beats never lower and raise tvalid in one step.
    task automatic send_request(input logic cmd, input logic [31:0] size,
                                input logic [4:0] lg);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {3'b000, lg, size};
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    // Write min_block_size only once the block has gone quiet.
    task automatic configure_min(input logic [32:0] value);
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        cur_min    = value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin : stimulus
        logic [32:0] phase_min [4];
        int unsigned sent;
        int unsigned mode;
        int unsigned len;
        logic [31:0] size;
        logic [31:0] span;
        logic [4:0]  lg;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed opening under the reset minimum:
        // reset on an empty table, zero size, max alignment code (clamped),
        // largest alignment, then max-size requests until the table is full,
        // one more to hit the full table, compaction and a single-block reset.
        send_request(CMD_RESET, 32'd0, 5'd0);
        send_request(CMD_ALLOC, 32'd0, 5'd0);
        send_request(CMD_ALLOC, 32'd1, 5'd31);
        send_request(CMD_ALLOC, 32'd100, 5'd16);
        send_request(CMD_ALLOC, SIZE_MAX, 5'd17);
        repeat (TABLE_DEPTH - 2) send_request(CMD_ALLOC, SIZE_MAX, 5'($urandom_range(0, 16)));
        send_request(CMD_ALLOC, SIZE_MAX, 5'd3);
        send_request(CMD_RESET, SIZE_MAX, 5'd31);
        send_request(CMD_ALLOC, 32'd12345, 5'd3);
        send_request(CMD_RESET, 32'd0, 5'd0);

        // Random phases: smallest, largest, reset value and a random multiple
        // of the largest alignment for the minimum block size.
        phase_min[0] = MIN_LOW;
        phase_min[1] = MIN_HIGH;
        phase_min[2] = MIN_RESET;
        phase_min[3] = 33'(64'd65536 * $urandom_range(1, 65536));

        for (int p = 0; p < 4; p++)
        begin
            configure_min(phase_min[p]);
            // first half of the third phase runs with no gaps on either side
            steady = (p == 2);
            sent   = 0;
            while (sent < PHASE_ITEMS)
            begin
                // Episode: a run of allocations closed by a reset. Mostly small
                // requests that share blocks, some around the minimum, and
                // bursts of huge ones that drive the table to full.
                mode = $urandom_range(0, 99);
                len  = (mode >= 85) ? $urandom_range(8, 24) : $urandom_range(1, 30);
                for (int k = 0; k < len; k++)
                begin
                    if (mode < 55)
                    begin
                        size = $urandom_range(0, 4096);
                    end
                    else if (mode < 85)
                    begin
                        span = (cur_min >= 33'h0_8000_0000) ? SIZE_MAX : 32'(cur_min * 2);
                        size = $urandom_range(0, span);
                    end
                    else
                    begin
                        size = ($urandom_range(0, 3) == 0) ? SIZE_MAX
                               : $urandom_range(32'hC000_0000, SIZE_MAX);
                    end
                    lg = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(17, 31))
                         : 5'($urandom_range(0, 16));
                    send_request(CMD_ALLOC, size, lg);
                    sent++;
                    if (p == 2 && sent == PHASE_ITEMS / 2)
                        steady = 1'b0;
                end
                // reset beats carry random payload that the block must ignore
                send_request(CMD_RESET, $urandom(), 5'($urandom_range(0, 31)));
                sent++;
                if (p == 2 && sent == PHASE_ITEMS / 2)
                    steady = 1'b0;
            end
        end

        // Drain: wait for every owed result, then give stray beats a chance.
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
